FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define CRA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define CRA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/cra_pkg.sv
`default_nettype none
package cra_pkg;

    localparam int ADDR_BITS = 20;

    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_REPORT  = 2'd2;
    localparam logic [1:0] REQ_UNUSED  = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_BAD   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSPACE  = 3'd1;
    localparam logic [2:0] ST_EXCEEDS  = 3'd2;
    localparam logic [2:0] ST_BADFIT   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  owner_id;
        logic [20:0] alloc_size;
        logic [1:0]  fit_mode;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] region_base;
        logic [20:0] region_end;
        logic [7:0]  region_owner;
        logic        region_free;
        logic        last;
    } rsp_t;

endpackage
`default_nettype wire

FILE: src/cra_table.sv
`default_nettype none
`include "assert_macros.svh"
module cra_table #(
    parameter int DEPTH = 32,
    parameter int W     = 51
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     init,
    input  wire logic [W-1:0]             init_data,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [W-1:0]             rdata,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [W-1:0]             wdata
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] raw_reg;
    logic         fresh0_reg;
    logic         sel_init_reg;

    // Entry 0 reads as the whole free memory until it is first written.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fresh0_reg   <= 1'b1;
            sel_init_reg <= 1'b0;
        end
        else
        begin
            if (init)
                fresh0_reg <= 1'b1;
            else if (we && waddr == AW'(0))
                fresh0_reg <= 1'b0;
            if (re)
                sel_init_reg <= fresh0_reg && raddr == AW'(0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            raw_reg <= mem[raddr];
    end

    assign rdata = sel_init_reg ? init_data : raw_reg;

    `CRA_ASSERT_IMP(a_no_rw_clash, we && re, waddr != raddr, "read and write hit one entry")
    `CRA_ASSERT_NXT(a_init_clears, init, fresh0_reg, "entry 0 not restored after init")
    `CRA_ASSERT_IMP(a_init_quiet, init, !we, "table written during init")

endmodule
`default_nettype wire

FILE: src/contiguous_region_allocator_unit.sv
// Contiguous region allocator: an address-ordered table of up to MAX_REGIONS
// half-open regions held in one synchronous RAM (one read, one write port).
// A release, or an allocate that passes the size and fit checks, walks the
// table one entry per cycle. A split shifts later entries up, then writes the
// free remainder and the allocated region; a release writes the merged free
// region, then shifts later entries down to close the gap. The result waits
// while the output stalls. A report reads each region from the RAM, then
// loads it as an output beat. One request is worked on at a time; in_ready
// is high only when the previous request has queued its last beat. Writing
// cfg_wr_data re-initialises the table to one free region at once.
`default_nettype none
`include "assert_macros.svh"
module contiguous_region_allocator_unit #(
    parameter int MAX_REGIONS = 32
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cra_pkg::req_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output cra_pkg::rsp_t      out_data,
    input  wire logic          cfg_wr_en,
    input  wire logic [20:0]   cfg_wr_data
);
    localparam int IDX_W = $clog2(MAX_REGIONS);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam int SZ_W  = (cra_pkg::ADDR_BITS + 1 > 21) ? cra_pkg::ADDR_BITS + 1 : 21;
    localparam int ENT_W = 2 * SZ_W + 9;
    localparam logic [32:0] LIMIT = 33'(1) << cra_pkg::ADDR_BITS;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SCAN   = 9'b000000010,
        S_DECIDE = 9'b000000100,
        S_SHIFT  = 9'b000001000,
        S_WR_A   = 9'b000010000,
        S_WR_B   = 9'b000100000,
        S_EMIT   = 9'b001000000,
        S_REP_RD = 9'b010000000,
        S_REP_WT = 9'b100000000
    } state_t;

    state_t              state_reg, state_next;
    cra_pkg::req_t       req_reg;
    logic [SZ_W-1:0]     mem_size_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    rd_idx_reg;
    logic                pend_reg;
    logic [IDX_W-1:0]    dat_idx_reg;
    logic                found_reg;
    logic [IDX_W-1:0]    pick_idx_reg;
    logic [SZ_W-1:0]     pick_base_reg, pick_end_reg, pick_len_reg;
    logic [SZ_W-1:0]     last_base_reg, prev_base_reg, next_end_reg;
    logic                last_free_reg, prev_free_reg, next_free_reg, have_next_reg;
    logic [CNT_W-1:0]    sh_left_reg;
    logic [IDX_W-1:0]    sh_cur_reg;
    logic                sh_up_reg;
    logic [1:0]          sh_dist_reg;
    cra_pkg::rsp_t       res_reg;
    logic                out_valid_reg;
    cra_pkg::rsp_t       out_data_reg;

    // table port
    logic                tbl_re, tbl_we;
    logic [IDX_W-1:0]    tbl_raddr, tbl_waddr;
    logic [ENT_W-1:0]    tbl_rdata, tbl_wdata, tbl_init_data;

    logic [SZ_W-1:0]     rd_base, rd_end, rd_len, req_size, cfg_size;
    logic [7:0]          rd_owner;
    logic                rd_free;
    logic                slot_free, accept, is_alloc, pf, nf, alloc_take, rel_match;
    logic [CNT_W-1:0]    rel_src;
    logic [1:0]          rel_dist;
    logic [2:0]          acc_status;

    assign rd_base  = tbl_rdata[ENT_W-1 -: SZ_W];
    assign rd_end   = tbl_rdata[ENT_W-1-SZ_W -: SZ_W];
    assign rd_owner = tbl_rdata[8:1];
    assign rd_free  = tbl_rdata[0];
    assign rd_len   = rd_end - rd_base;
    assign req_size = SZ_W'(req_reg.alloc_size);

    // entry 0 after reset or a size write: the whole managed memory, free
    assign tbl_init_data = {SZ_W'(0), mem_size_reg, 8'd0, 1'b1};

    // saturate the written size into 1 .. 2^ADDR_BITS
    always_comb
    begin
        if (cfg_wr_data == 21'd0)
            cfg_size = SZ_W'(1);
        else if (33'(cfg_wr_data) > LIMIT)
            cfg_size = SZ_W'(LIMIT);
        else
            cfg_size = SZ_W'(cfg_wr_data);
    end

    // status held for a request that ends without a region
    always_comb
    begin
        if (in_data.req_type == cra_pkg::REQ_RELEASE)
            acc_status = cra_pkg::ST_NOTFOUND;
        else if (SZ_W'(in_data.alloc_size) > mem_size_reg)
            acc_status = cra_pkg::ST_EXCEEDS;
        else if (in_data.fit_mode == cra_pkg::FIT_BAD)
            acc_status = cra_pkg::ST_BADFIT;
        else
            acc_status = cra_pkg::ST_NOSPACE;
    end

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign is_alloc  = (req_reg.req_type == cra_pkg::REQ_ALLOC);

    // release merge: neighbours that are free fold into the freed region
    assign pf       = (pick_idx_reg != IDX_W'(0)) && prev_free_reg;
    assign nf       = have_next_reg && next_free_reg;
    assign rel_dist = {1'b0, pf} + {1'b0, nf};
    assign rel_src  = CNT_W'(pick_idx_reg) + CNT_W'(1) + CNT_W'(nf);

    assign alloc_take = rd_free && rd_len >= req_size
        && (!found_reg
            || (req_reg.fit_mode == cra_pkg::FIT_BEST  && rd_len < pick_len_reg)
            || (req_reg.fit_mode == cra_pkg::FIT_WORST && rd_len > pick_len_reg));
    assign rel_match  = !found_reg && !rd_free && rd_owner == req_reg.owner_id;

    // table access per state
    always_comb
    begin
        tbl_re    = 1'b0;
        tbl_raddr = rd_idx_reg[IDX_W-1:0];
        tbl_we    = 1'b0;
        tbl_waddr = pick_idx_reg;
        tbl_wdata = {pick_base_reg, pick_base_reg + req_size, req_reg.owner_id, 1'b0};
        unique case (state_reg)
            S_SCAN:
            begin
                tbl_re = rd_idx_reg < count_reg;
            end
            S_SHIFT:
            begin
                tbl_re    = sh_left_reg != CNT_W'(0);
                tbl_raddr = sh_cur_reg;
                tbl_we    = pend_reg;
                tbl_waddr = sh_up_reg ? dat_idx_reg + IDX_W'(1)
                                      : dat_idx_reg - IDX_W'(sh_dist_reg);
                tbl_wdata = tbl_rdata;
            end
            S_WR_A:
            begin
                tbl_we = 1'b1;
                if (is_alloc)
                begin
                    tbl_waddr = pick_idx_reg + IDX_W'(1);
                    tbl_wdata = {pick_base_reg + req_size, pick_end_reg, 8'd0, 1'b1};
                end
                else
                begin
                    tbl_waddr = pf ? pick_idx_reg - IDX_W'(1) : pick_idx_reg;
                    tbl_wdata = {pf ? prev_base_reg : pick_base_reg,
                                 nf ? next_end_reg : pick_end_reg, 8'd0, 1'b1};
                end
            end
            S_WR_B:
            begin
                tbl_we = 1'b1;
            end
            S_REP_RD:
            begin
                tbl_re = slot_free;
            end
            S_IDLE, S_DECIDE, S_EMIT, S_REP_WT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    cra_table #(
        .DEPTH (MAX_REGIONS),
        .W     (ENT_W)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .init      (cfg_wr_en),
        .init_data (tbl_init_data),
        .re        (tbl_re),
        .raddr     (tbl_raddr),
        .rdata     (tbl_rdata),
        .we        (tbl_we),
        .waddr     (tbl_waddr),
        .wdata     (tbl_wdata)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.req_type)
                        cra_pkg::REQ_ALLOC:
                        begin
                            if (SZ_W'(in_data.alloc_size) > mem_size_reg
                                || in_data.fit_mode == cra_pkg::FIT_BAD
                                || in_data.alloc_size == 21'd0)
                                state_next = S_EMIT;
                            else
                                state_next = S_SCAN;
                        end
                        cra_pkg::REQ_RELEASE: state_next = S_SCAN;
                        cra_pkg::REQ_REPORT:  state_next = S_REP_RD;
                        default:              state_next = S_IDLE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_idx_reg == count_reg && !pend_reg)
                    state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (!found_reg)
                    state_next = S_EMIT;
                else if (!is_alloc)
                    state_next = S_WR_A;
                else if (pick_len_reg == req_size)
                    state_next = S_WR_B;
                else if (count_reg >= CNT_W'(MAX_REGIONS))
                    state_next = S_EMIT;
                else
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sh_left_reg == CNT_W'(0) && !pend_reg)
                    state_next = is_alloc ? S_WR_A : S_EMIT;
            end
            S_WR_A:   state_next = is_alloc ? S_WR_B : S_SHIFT;
            S_WR_B:   state_next = S_EMIT;
            S_EMIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            S_REP_RD:
            begin
                if (slot_free)
                    state_next = S_REP_WT;
            end
            S_REP_WT:
            begin
                state_next = (CNT_W'(dat_idx_reg) + CNT_W'(1) == count_reg) ? S_IDLE
                                                                             : S_REP_RD;
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mem_size_reg  <= SZ_W'(LIMIT);
            count_reg     <= CNT_W'(1);
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                mem_size_reg <= cfg_size;
                count_reg    <= CNT_W'(1);
            end
            else if (state_reg == S_WR_A)
            begin
                if (is_alloc)
                    count_reg <= count_reg + CNT_W'(1);
                else
                    count_reg <= count_reg - CNT_W'(rel_dist);
            end

            // output register: load on a new beat, drop when taken
            if ((state_reg == S_EMIT && slot_free) || state_reg == S_REP_WT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            pend_reg <= tbl_re && (state_reg == S_SCAN || state_reg == S_SHIFT);
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (tbl_re)
            dat_idx_reg <= tbl_raddr;

        if (accept)
        begin
            req_reg       <= in_data;
            rd_idx_reg    <= CNT_W'(0);
            found_reg     <= 1'b0;
            have_next_reg <= 1'b0;
            last_free_reg <= 1'b0;
            last_base_reg <= SZ_W'(0);
            res_reg       <= '{status: acc_status, region_base: 20'd0, region_end: 21'd0,
                               region_owner: 8'd0, region_free: 1'b0, last: 1'b1};
        end

        if (tbl_re && (state_reg == S_SCAN || state_reg == S_REP_RD))
            rd_idx_reg <= rd_idx_reg + CNT_W'(1);

        // scan: compare each entry as it returns from the RAM
        if (state_reg == S_SCAN && pend_reg)
        begin
            last_base_reg <= rd_base;
            last_free_reg <= rd_free;
            if (is_alloc ? alloc_take : rel_match)
            begin
                found_reg     <= 1'b1;
                pick_idx_reg  <= dat_idx_reg;
                pick_base_reg <= rd_base;
                pick_end_reg  <= rd_end;
                pick_len_reg  <= rd_len;
                prev_base_reg <= last_base_reg;
                prev_free_reg <= last_free_reg;
            end
            if (found_reg && dat_idx_reg == pick_idx_reg + IDX_W'(1))
            begin
                have_next_reg <= 1'b1;
                next_end_reg  <= rd_end;
                next_free_reg <= rd_free;
            end
        end

        if (state_reg == S_DECIDE)
        begin
            sh_up_reg   <= 1'b1;
            sh_dist_reg <= 2'd1;
            sh_left_reg <= count_reg - CNT_W'(1) - CNT_W'(pick_idx_reg);
            sh_cur_reg  <= IDX_W'(count_reg - CNT_W'(1));
            if (found_reg)
            begin
                if (!is_alloc)
                    res_reg <= '{status: cra_pkg::ST_OK,
                                 region_base: pick_base_reg[19:0],
                                 region_end: pick_end_reg[20:0],
                                 region_owner: 8'd0, region_free: 1'b1, last: 1'b1};
                else if (pick_len_reg != req_size && count_reg >= CNT_W'(MAX_REGIONS))
                    res_reg.status <= cra_pkg::ST_FULL;
                else
                    res_reg <= '{status: cra_pkg::ST_OK,
                                 region_base: pick_base_reg[19:0],
                                 region_end: 21'(pick_base_reg + req_size),
                                 region_owner: req_reg.owner_id,
                                 region_free: 1'b0, last: 1'b1};
            end
        end

        // release: set up the shift-down that closes the gap
        if (state_reg == S_WR_A && !is_alloc)
        begin
            sh_up_reg   <= 1'b0;
            sh_dist_reg <= rel_dist;
            sh_left_reg <= (rel_dist != 2'd0) ? count_reg - rel_src : CNT_W'(0);
            sh_cur_reg  <= rel_src[IDX_W-1:0];
        end

        if (state_reg == S_SHIFT && tbl_re)
        begin
            sh_left_reg <= sh_left_reg - CNT_W'(1);
            sh_cur_reg  <= sh_up_reg ? sh_cur_reg - IDX_W'(1) : sh_cur_reg + IDX_W'(1);
        end

        if (state_reg == S_EMIT && slot_free)
            out_data_reg <= res_reg;
        if (state_reg == S_REP_WT)
            out_data_reg <= '{status: cra_pkg::ST_OK,
                              region_base: rd_base[19:0],
                              region_end: rd_end[20:0],
                              region_owner: rd_free ? 8'd0 : rd_owner,
                              region_free: rd_free,
                              last: CNT_W'(dat_idx_reg) + CNT_W'(1) == count_reg};
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `CRA_ASSERT_IMP(a_count_range, 1'b1,
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_REGIONS), "region count out of range")
    `CRA_ASSERT_IMP(a_write_busy, tbl_we, state_reg != S_IDLE, "table written while idle")
    `CRA_ASSERT_NXT(a_alloc_grows, state_reg == S_WR_A && is_alloc,
        count_reg == $past(count_reg) + CNT_W'(1), "split did not add an entry")

endmodule
`default_nettype wire
